[hdl/postings_delta_writer_defines.svh]
// Assertion macros for the postings delta writer checker.
// Each macro expects signals named clk and arst_n in the scope that uses it.
`ifndef POSTINGS_DELTA_WRITER_DEFINES_SVH
`define POSTINGS_DELTA_WRITER_DEFINES_SVH

// Check an implication in the same cycle.
`define PDW_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("postings delta writer: same-cycle check failed");

// Check an implication in the next cycle.
`define PDW_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("postings delta writer: next-cycle check failed");

// Check that a condition never holds.
`define PDW_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("postings delta writer: forbidden condition seen");

`endif

[hdl/pdw_pkg.sv]
// Shared types and constants of the postings delta writer.
// Used by the core, the register block, the top level and the checker.
package pdw_pkg;

	// Table geometry
	localparam int TERMS  = 4096;
	localparam int TIDX_W = $clog2(TERMS);

	// Field widths
	localparam int TID_W  = 12;
	localparam int DOC_W  = 31;
	localparam int POS_W  = 31;
	localparam int PLEN_W = 16;
	localparam int CODE_W = 32;
	localparam int FREQ_W = 31;
	localparam int WORD_W = 32;

	// Stream packing
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 64;
	localparam int TID_LSB     = 0;
	localparam int DOC_LSB     = TID_LSB + TID_W;
	localparam int POS_LSB     = DOC_LSB + DOC_W;
	localparam int PLEN_LSB    = POS_LSB + POS_W;

	// Register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_OMIT_FREQ_POS = 1'b0;

	// Result word buffer
	localparam int MAX_WORDS = 4;
	localparam int WCNT_W    = $clog2(MAX_WORDS + 1);
	localparam int WIDX_W    = $clog2(MAX_WORDS);

	// Stream codes
	localparam logic STREAM_DOC = 1'b0;
	localparam logic STREAM_POS = 1'b1;

	// Command codes
	localparam logic CMD_FIRST = 1'b0;
	localparam logic CMD_LATER = 1'b1;

	localparam logic [FREQ_W-1:0] FREQ_MAX = {FREQ_W{1'b1}};
	localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1);

	typedef struct packed {
		logic [DOC_W-1:0]  last_doc;
		logic [CODE_W-1:0] pending_code;
		logic [FREQ_W-1:0] doc_freq;
		logic [POS_W-1:0]  last_pos;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic omit_freq_pos;
	} cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SEND
	} state_t;

endpackage

[hdl/pdw_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency; depth and width come from parameters.
module pdw_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 125,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/pdw_cfg.sv]
// APB register block of the postings delta writer: holds omit_freq_pos.
// Depends on pdw_pkg for the port widths and the register code.
module pdw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pdw_pkg::PADDR_W-1:0]   paddr,
	input  logic [pdw_pkg::PDATA_W-1:0]   pwdata,
	output logic [pdw_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	output pdw_pkg::cfg_t                 cfg
);
	import pdw_pkg::*;

	logic omit_q;
	logic wr_en;
	logic reg_sel;

	// Decode the register index from the word address
	assign reg_sel = (paddr[PADDR_W-1] == REG_OMIT_FREQ_POS);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;

	// Hold the mode bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			omit_q <= 1'b0;
		end else if (wr_en && reg_sel) begin
			omit_q <= pwdata[0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata[0] = omit_q;
		end
	end

	assign cfg.omit_freq_pos = omit_q;

endmodule

[hdl/pdw_core.sv]
// Core of the postings delta writer: sequencer, table read-modify-write and
// result word buffer. Depends on pdw_pkg and instantiates pdw_ram.
module pdw_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pdw_pkg::cfg_t                   cfg,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [pdw_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [0:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pdw_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast
);
	import pdw_pkg::*;

	state_t state_q, state_d;

	// Captured transaction
	logic              cmd_q;
	logic [TIDX_W-1:0] idx_q;
	logic              inr_q;
	logic [DOC_W-1:0]  doc_q;
	logic [POS_W-1:0]  pos_q;
	logic [PLEN_W-1:0] plen_q;

	logic [TID_W-1:0]  in_tid;
	logic [TIDX_W-1:0] in_idx;
	logic              in_acc;

	// Table access
	logic   ram_we;
	logic   ram_re;
	entry_t rd_entry;
	entry_t wr_entry;
	logic [ENTRY_W-1:0] ram_rdata;

	// Max frequency and word buffer
	logic [FREQ_W-1:0] max_q, max_d;
	logic              wstr_q [MAX_WORDS];
	logic [WORD_W-1:0] wval_q [MAX_WORDS];
	logic [WCNT_W-1:0] wcnt_q;
	logic [WIDX_W-1:0] rd_q;
	logic              wstr_d [MAX_WORDS];
	logic [WORD_W-1:0] wval_d [MAX_WORDS];
	logic [WCNT_W-1:0] wcnt_d;
	logic              out_last;

	assign in_tid = s_tdata[DOC_LSB-1:TID_LSB];
	assign in_idx = TIDX_W'(in_tid);
	assign in_acc = s_tvalid && s_tready;

	pdw_ram #(
		.DEPTH(TERMS),
		.WIDTH(ENTRY_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	assign rd_entry = entry_t'(ram_rdata);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) state_d = ST_LOOKUP;
			end
			ST_LOOKUP: begin
				if (wcnt_d == '0) state_d = ST_IDLE;
				else state_d = ST_SEND;
			end
			ST_SEND: begin
				if (m_tready && out_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		ram_re   = 1'b0;
		ram_we   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				ram_re   = 1'b1;
			end
			ST_LOOKUP: ram_we = inr_q;
			ST_SEND:   m_tvalid = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q  <= s_tuser[0];
			idx_q  <= in_idx;
			inr_q  <= (32'(in_tid) < TERMS);
			doc_q  <= s_tdata[POS_LSB-1:DOC_LSB];
			pos_q  <= s_tdata[PLEN_LSB-1:POS_LSB];
			plen_q <= s_tdata[PLEN_LSB+PLEN_W-1:PLEN_LSB];
		end
	end

	// Modify the entry and collect the result words
	always_comb begin
		logic              omit;
		logic              do_pos;
		logic [POS_W-1:0]  pdelta;
		logic [FREQ_W-1:0] bump;
		logic [FREQ_W-1:0] finc;
		logic [WORD_W-1:0] pcode;
		logic [DOC_W-1:0]  ddelta;
		omit     = cfg.omit_freq_pos;
		do_pos   = 1'b0;
		pdelta   = pos_q;
		pcode    = '0;
		bump     = '0;
		finc     = (rd_entry.doc_freq == FREQ_MAX) ? FREQ_MAX : rd_entry.doc_freq + FREQ_ONE;
		ddelta   = doc_q - rd_entry.last_doc;
		wr_entry = rd_entry;
		wcnt_d   = '0;
		for (int i = 0; i < MAX_WORDS; i++) begin
			wstr_d[i] = STREAM_DOC;
			wval_d[i] = '0;
		end
		if (inr_q) begin
			if (cmd_q == CMD_FIRST) begin
				wr_entry.last_doc = doc_q;
				bump = FREQ_ONE;
				if (omit) begin
					wr_entry.pending_code = CODE_W'(doc_q);
				end else begin
					wr_entry.pending_code = {doc_q, 1'b0};
					wr_entry.doc_freq     = FREQ_ONE;
					do_pos = 1'b1;
				end
			end else if (omit) begin
				if (doc_q != rd_entry.last_doc) begin
					wval_d[0] = rd_entry.pending_code;
					wcnt_d    = WCNT_W'(1);
					wr_entry.pending_code = CODE_W'(ddelta);
					wr_entry.last_doc     = doc_q;
				end
			end else if (doc_q != rd_entry.last_doc) begin
				if (rd_entry.doc_freq == FREQ_ONE) begin
					wval_d[0] = {rd_entry.pending_code[CODE_W-1:1], 1'b1};
					wcnt_d    = WCNT_W'(1);
				end else begin
					wval_d[0] = rd_entry.pending_code;
					wval_d[1] = WORD_W'(rd_entry.doc_freq);
					wcnt_d    = WCNT_W'(2);
				end
				wr_entry.doc_freq     = FREQ_ONE;
				wr_entry.pending_code = {ddelta, 1'b0};
				wr_entry.last_doc     = doc_q;
				bump   = FREQ_ONE;
				do_pos = 1'b1;
			end else begin
				wr_entry.doc_freq = finc;
				bump   = finc;
				pdelta = pos_q - rd_entry.last_pos;
				do_pos = 1'b1;
			end
		end
		// Append the position words
		if (do_pos) begin
			wr_entry.last_pos = pos_q;
			pcode = {pdelta, 1'b0};
			wstr_d[WIDX_W'(wcnt_d)] = STREAM_POS;
			if (plen_q != '0) begin
				wval_d[WIDX_W'(wcnt_d)] = {pcode[WORD_W-1:1], 1'b1};
				wstr_d[WIDX_W'(wcnt_d + WCNT_W'(1))] = STREAM_POS;
				wval_d[WIDX_W'(wcnt_d + WCNT_W'(1))] = WORD_W'(plen_q);
				wcnt_d = wcnt_d + WCNT_W'(2);
			end else begin
				wval_d[WIDX_W'(wcnt_d)] = pcode;
				wcnt_d = wcnt_d + WCNT_W'(1);
			end
		end
		max_d = (bump > max_q) ? bump : max_q;
	end

	// Track the maximum frequency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
		end else if (state_q == ST_LOOKUP) begin
			max_q <= max_d;
		end
	end

	// Load the word buffer and advance the read slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wcnt_q <= '0;
			rd_q   <= '0;
		end else if (state_q == ST_LOOKUP) begin
			wcnt_q <= wcnt_d;
			rd_q   <= '0;
		end else if (m_tvalid && m_tready) begin
			rd_q <= rd_q + WIDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOOKUP) begin
			for (int i = 0; i < MAX_WORDS; i++) begin
				wstr_q[i] <= wstr_d[i];
				wval_q[i] <= wval_d[i];
			end
		end
	end

	// Drive the result channel
	assign out_last   = (WCNT_W'(rd_q) + WCNT_W'(1) == wcnt_q);
	assign m_tlast    = out_last;
	assign m_tuser[0] = wstr_q[rd_q];
	assign m_tdata    = {1'b0, max_q, wval_q[rd_q]};

endmodule

[hdl/postings_delta_writer.sv]
// Postings delta writer: one term occurrence in, up to four coded words out.
// Slave channel s_*: one transaction per occurrence. Master channel m_*: one
// transaction per word; tuser gives the stream (0 documents, 1 positions),
// tlast marks the final word of an occurrence. APB port: omit_freq_pos at 0.
// Each occurrence takes an accept cycle and a table cycle (synchronous
// term table, one read and one write port), then one cycle per word on the
// master side while m_tready is high. The first word, if any, becomes valid
// after the table cycle. One occurrence is in flight at a time:
// s_tready is high only when all words of the previous one have been taken.
// A stalled receiver holds the current word and blocks new occurrences.
// Reset clears the sequencer, the word count, the mode bit and the maximum
// frequency; the term table is not cleared, and a term must be opened with
// cmd 0 before a later occurrence refers to it. Configuration writes belong
// to idle periods.
// Depends on pdw_pkg, pdw_cfg, pdw_core and pdw_ram.
module postings_delta_writer (
	input  logic                            clk,
	input  logic                            arst_n,
	// APB configuration port
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [pdw_pkg::PADDR_W-1:0]     paddr,
	input  logic [pdw_pkg::PDATA_W-1:0]     pwdata,
	output logic [pdw_pkg::PDATA_W-1:0]     prdata,
	output logic                            pready,
	// Occurrence input
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// term_id[11:0], doc_id[42:12], position[73:43], payload_len[89:74], zero fill
	input  logic [pdw_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic [0:0]                      s_tuser,
	// Word output
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// value[31:0], max_term_freq[62:32], zero fill
	output logic [pdw_pkg::OUT_TDATA_W-1:0] m_tdata,
	// stream[0]
	output logic [0:0]                      m_tuser,
	output logic                            m_tlast
);
	import pdw_pkg::*;

	cfg_t cfg;

	pdw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pdw_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[hdl/pdw_checker.sv]
// Port-level checker for the postings delta writer, bound to the top level.
// Depends on pdw_pkg and the macros in postings_delta_writer_defines.svh.
`include "postings_delta_writer_defines.svh"

module pdw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pdw_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic                            m_tlast
);
	import pdw_pkg::*;

	// A stalled word holds its data
	`PDW_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// No new occurrence is taken while words are pending
	`PDW_ASSERT_NEVER(a_one_at_a_time, s_tready && m_tvalid)

	// The table cycle follows every accepted occurrence
	`PDW_ASSERT_NEXT(a_lookup_gap, s_tvalid && s_tready, !s_tready)

	// Words of one occurrence carry the same maximum frequency
	`PDW_ASSERT_NEXT(a_max_same, m_tvalid && m_tready && !m_tlast,
		m_tvalid && (m_tdata[OUT_TDATA_W-2:WORD_W] == $past(m_tdata[OUT_TDATA_W-2:WORD_W])))

endmodule

bind postings_delta_writer pdw_checker u_pdw_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);
